### src/srd_pkg.sv
// ----------------------------------------------------------------------------
// srd_pkg
// shared types and constants for the record deframer
// ----------------------------------------------------------------------------
package srd_pkg;

    // header: 2 length bytes then 8 sequence bytes, both big endian
    localparam logic [3:0] HEADER_BYTES = 4'd10;
    localparam logic [3:0] LEN_BYTES    = 4'd2;

    localparam int DATA_W = 8;
    localparam int PIDX_W = 10;
    localparam int LEN_W  = 16;
    localparam int SEQ_W  = 64;

    localparam logic [SEQ_W-1:0] SEQ_ALL_ONES = {SEQ_W{1'b1}};

    typedef enum logic [2:0] {
        KIND_IGNORED = 3'd0,
        KIND_HEADER  = 3'd1,
        KIND_PAYLOAD = 3'd2,
        KIND_TAG     = 3'd3,
        KIND_REJECT  = 3'd4,
        KIND_STARTED = 3'd5
    } kind_t;

    typedef enum logic [0:0] {
        OP_BYTE    = 1'b0,
        OP_RESTART = 1'b1
    } opcode_t;

    // fixed-width part of the session and record state
    typedef struct packed {
        logic              in_session;
        logic [3:0]        header_count;
        logic [LEN_W-1:0]  length_field;
        logic [SEQ_W-1:0]  sequence_field;
        logic [SEQ_W-1:0]  expected_sequence;
    } sess_t;

    // one result word
    typedef struct packed {
        kind_t             kind;
        logic [DATA_W-1:0] data;
        logic [PIDX_W-1:0] payload_index;
        logic [LEN_W-1:0]  record_length;
        logic [SEQ_W-1:0]  record_sequence;
        logic              record_done;
    } result_t;

endpackage

### src/srd_step.sv
// ----------------------------------------------------------------------------
// srd_step
// next-state and result logic for one received word
// ----------------------------------------------------------------------------
module srd_step
    import srd_pkg::*;
#(
    parameter int MAX_RECORD = 1024,
    parameter int TAG_BYTES  = 16,
    parameter int PCW        = $clog2(MAX_RECORD + 1),
    parameter int TCW        = $clog2(TAG_BYTES + 1)
) (
    input  opcode_t           opcode,
    input  logic [DATA_W-1:0] rx_byte,
    input  sess_t             sess,
    input  logic [PCW-1:0]    payload_count,
    input  logic [TCW-1:0]    tag_count,
    output sess_t             sess_next,
    output logic [PCW-1:0]    payload_count_next,
    output logic [TCW-1:0]    tag_count_next,
    output result_t           result
);

    localparam logic [LEN_W:0]   MAX_LEN  = (LEN_W + 1)'(MAX_RECORD);
    localparam logic [TCW-1:0]   TAG_LAST = TCW'(TAG_BYTES - 1);

    logic [LEN_W-1:0] len_shift;
    logic [SEQ_W-1:0] seq_shift;
    logic             header_bad;

    assign len_shift = {sess.length_field[LEN_W-DATA_W-1:0], rx_byte};
    assign seq_shift = {sess.sequence_field[SEQ_W-DATA_W-1:0], rx_byte};

    always_comb begin
        sess_next          = sess;
        payload_count_next = payload_count;
        tag_count_next     = tag_count;
        result             = '0;
        result.kind        = KIND_IGNORED;
        header_bad         = 1'b0;

        if (opcode == OP_RESTART) begin
            sess_next          = '0;
            sess_next.in_session = 1'b1;
            payload_count_next = '0;
            tag_count_next     = '0;
            result.kind        = KIND_STARTED;
        end else if (sess.in_session) begin
            if (sess.header_count < HEADER_BYTES) begin
                if (sess.header_count < LEN_BYTES) begin
                    sess_next.length_field = len_shift;
                end else begin
                    sess_next.sequence_field = seq_shift;
                end
                sess_next.header_count = sess.header_count + 4'd1;
                result.kind            = KIND_HEADER;
                result.record_length   = sess_next.length_field;
                result.record_sequence = sess_next.sequence_field;
                header_bad = (sess_next.length_field == '0)
                           || ({1'b0, sess_next.length_field} > MAX_LEN)
                           || (sess_next.sequence_field != sess.expected_sequence);
                if ((sess_next.header_count == HEADER_BYTES) && header_bad) begin
                    result.kind        = KIND_REJECT;
                    sess_next          = '0;
                    payload_count_next = '0;
                    tag_count_next     = '0;
                end
            end else if (LEN_W'(payload_count) < sess.length_field) begin
                result.kind            = KIND_PAYLOAD;
                result.data            = rx_byte;
                result.payload_index   = PIDX_W'(payload_count);
                result.record_length   = sess.length_field;
                result.record_sequence = sess.sequence_field;
                payload_count_next     = payload_count + PCW'(1);
            end else begin
                result.kind            = KIND_TAG;
                result.data            = rx_byte;
                result.record_length   = sess.length_field;
                result.record_sequence = sess.sequence_field;
                tag_count_next         = tag_count + TCW'(1);
                if (tag_count == TAG_LAST) begin
                    payload_count_next = '0;
                    tag_count_next     = '0;
                    if (sess.expected_sequence == SEQ_ALL_ONES) begin
                        result.kind = KIND_REJECT;
                        result.data = '0;
                        sess_next   = '0;
                    end else begin
                        // record complete, clear assembly and move on
                        result.record_done          = 1'b1;
                        sess_next.header_count      = '0;
                        sess_next.length_field      = '0;
                        sess_next.sequence_field    = '0;
                        sess_next.expected_sequence = sess.expected_sequence + SEQ_W'(1);
                    end
                end
            end
        end
    end

endmodule

### src/secure_record_deframer_core.sv
// ----------------------------------------------------------------------------
// secure_record_deframer_core
// splits received link bytes into length-prefixed records and checks headers
// ----------------------------------------------------------------------------
// usage
//   input stream: one word per link byte; s_axis_tuser selects a link byte or
//   a session restart, s_axis_tdata carries the byte
//   output stream: exactly one word per input word, in order; m_axis_tuser
//   gives the kind (ignored, header, payload, tag, rejected, started),
//   m_axis_tlast marks the last tag byte of an accepted record
//   path: each accepted input word goes into the input register, then its
//   result is written by the step logic into the result register
//   throughput: one word per cycle while m_axis_tready is high; session
//   counters, 64-bit sequence compare and increment all settle in one step stage
//   reset: aresetn low closes the session and clears all record state;
//   both stream registers drop valid
//   stall: when m_axis_tready is low the result holds, the input register
//   still fills once, then s_axis_tready falls until the result is taken
//   records: 10 header bytes (length, sequence, big endian), length payload
//   bytes, then TAG_BYTES tag bytes
// ----------------------------------------------------------------------------
module secure_record_deframer_core
    import srd_pkg::*;
#(
    parameter int MAX_RECORD = 1024,
    parameter int TAG_BYTES  = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    // input stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] rx_byte
    input  logic [0:0]   s_axis_tuser,   // [0] opcode
    // result stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [103:0] m_axis_tdata,   // [7:0] data, [17:8] payload_index,
                                         // [33:18] record_length,
                                         // [97:34] record_sequence, rest zero
    output logic [2:0]   m_axis_tuser,   // [2:0] kind
    output logic         m_axis_tlast    // record_done
);

    localparam int PCW = $clog2(MAX_RECORD + 1);
    localparam int TCW = $clog2(TAG_BYTES + 1);

    // input register
    logic              in_valid_reg;
    opcode_t           in_op_reg;
    logic [DATA_W-1:0] in_byte_reg;

    // session state
    sess_t             sess_reg;
    sess_t             sess_next;
    logic [PCW-1:0]    pcount_reg;
    logic [PCW-1:0]    pcount_next;
    logic [TCW-1:0]    tcount_reg;
    logic [TCW-1:0]    tcount_next;

    // result register
    logic              out_valid_reg;
    result_t           out_reg;
    result_t           out_next;

    logic              advance;
    logic              s_accept;

    // step runs when an item waits and the result slot is free or draining
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    srd_step #(
        .MAX_RECORD (MAX_RECORD),
        .TAG_BYTES  (TAG_BYTES),
        .PCW        (PCW),
        .TCW        (TCW)
    ) u_step (
        .opcode             (in_op_reg),
        .rx_byte            (in_byte_reg),
        .sess               (sess_reg),
        .payload_count      (pcount_reg),
        .tag_count          (tcount_reg),
        .sess_next          (sess_next),
        .payload_count_next (pcount_next),
        .tag_count_next     (tcount_next),
        .result             (out_next)
    );

    // control and session state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            sess_reg      <= '0;
            pcount_reg    <= '0;
            tcount_reg    <= '0;
        end else begin
            if (s_accept) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                sess_reg      <= sess_next;
                pcount_reg    <= pcount_next;
                tcount_reg    <= tcount_next;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_op_reg   <= opcode_t'(s_axis_tuser[0]);
            in_byte_reg <= s_axis_tdata;
        end
        if (advance) begin
            out_reg <= out_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.kind;
    assign m_axis_tlast  = out_reg.record_done;
    assign m_axis_tdata  = {6'd0, out_reg.record_sequence, out_reg.record_length,
                            out_reg.payload_index, out_reg.data};

endmodule
